[hw/rtl/dlp_pkg.sv]
// Shared types, character codes and base helpers for the DNA line packer.
package dlp_pkg;

  localparam int unsigned LEN_W    = 6;  // stored length of one line
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned Q_DEPTH  = 2;  // one record per line bank
  localparam int unsigned Q_PTR_W  = 1;
  localparam int unsigned Q_CNT_W  = 2;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam logic [7:0] CHAR_NL   = 8'd10;
  localparam logic [7:0] CHAR_ZERO = 8'd48;  // '0'
  localparam logic [7:0] CHAR_ONE  = 8'd49;  // '1'
  localparam logic [7:0] CHAR_FIVE = 8'd53;  // '5'
  localparam logic [7:0] CHAR_NINE = 8'd57;  // '9'
  localparam logic [7:0] CHAR_A    = 8'd65;
  localparam logic [7:0] CHAR_C    = 8'd67;
  localparam logic [7:0] CHAR_G    = 8'd71;
  localparam logic [7:0] CHAR_T    = 8'd84;

  localparam logic [1:0] CODE_A = 2'h0;
  localparam logic [1:0] CODE_T = 2'h1;
  localparam logic [1:0] CODE_C = 2'h2;
  localparam logic [1:0] CODE_G = 2'h3;

  // One finished line waiting for output
  typedef struct packed {
    logic             terminated;  // ended by a newline
    logic             only_bases;  // every byte was A, C, G or T
    logic [LEN_W-1:0] len;
  } rec_desc_t;

  function automatic logic is_base(input logic [7:0] b);
    return (b == CHAR_A) || (b == CHAR_T) || (b == CHAR_C) || (b == CHAR_G);
  endfunction

  function automatic logic [1:0] base_code(input logic [7:0] b);
    logic [1:0] code;
    code = CODE_A;
    if (b == CHAR_T) code = CODE_T;
    if (b == CHAR_C) code = CODE_C;
    if (b == CHAR_G) code = CODE_G;
    return code;
  endfunction

endpackage

[hw/rtl/dlp_ram.sv]
// Generic simple dual-port RAM with registered read data.
module dlp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 124
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dlp_front.sv]
// Intake side: stores line bytes into the current bank and closes lines.
module dlp_front #(
  parameter int unsigned CHUNK_MAX = 62
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_cmd_i,
  input  logic [7:0]                       in_byte_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output dlp_pkg::rec_desc_t               q_desc_o,
  output logic                             ram_we_o,
  output logic [$clog2(2*CHUNK_MAX)-1:0]   ram_waddr_o,
  output logic [7:0]                       ram_wdata_o
);
  import dlp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2*CHUNK_MAX);

  logic [LEN_W-1:0] fill_q, fill_d, fill_inc;
  logic             ob_q, ob_d, ob_nxt;
  logic             bank_q, bank_d;
  logic             accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_inc   = fill_q + LEN_W'(1);
  assign ob_nxt     = ob_q && is_base(in_byte_i);

  assign ram_wdata_o = in_byte_i;
  assign ram_waddr_o = bank_q ? (ADDR_W'(fill_q) + ADDR_W'(CHUNK_MAX)) : ADDR_W'(fill_q);

  always_comb begin
    fill_d   = fill_q;
    ob_d     = ob_q;
    bank_d   = bank_q;
    q_push_o = 1'b0;
    q_desc_o = '{terminated: 1'b0, only_bases: ob_q, len: fill_q};
    ram_we_o = 1'b0;
    if (accept) begin
      if (in_cmd_i == CMD_END) begin
        q_push_o = (fill_q != '0);
      end else if (in_byte_i == CHAR_NL) begin
        q_push_o            = 1'b1;
        q_desc_o.terminated = 1'b1;
      end else begin
        ram_we_o = 1'b1;
        fill_d   = fill_inc;
        ob_d     = ob_nxt;
        if (fill_inc == LEN_W'(CHUNK_MAX)) begin
          // full chunk: close it at once as an unterminated line
          q_push_o = 1'b1;
          q_desc_o = '{terminated: 1'b0, only_bases: ob_nxt, len: fill_inc};
        end
      end
      if (q_push_o) begin
        fill_d = '0;
        ob_d   = 1'b1;
        bank_d = !bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ob_q   <= 1'b1;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ob_q   <= ob_d;
      bank_q <= bank_d;
    end
  end

endmodule

[hw/rtl/dlp_queue.sv]
// Two-entry record queue between intake and output sides.
module dlp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dlp_pkg::rec_desc_t desc_i,
  output logic               full_o,
  input  logic               pop_i,
  output dlp_pkg::rec_desc_t head_o,
  output logic               empty_o
);
  import dlp_pkg::*;

  rec_desc_t            entry_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/dlp_back.sv]
// Output side: walks one stored line and sends its record beats.
module dlp_back #(
  parameter int unsigned CHUNK_MAX = 62
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  dlp_pkg::rec_desc_t             q_head_i,
  output logic                           q_pop_o,
  output logic                           ram_re_o,
  output logic [$clog2(2*CHUNK_MAX)-1:0] ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o,
  output logic                           out_last_o
);
  import dlp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2*CHUNK_MAX);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TYPE = 3'd1;
  localparam logic [2:0] S_LEN  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_USE  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [LEN_W-1:0] idx_q, idx_d;
  logic [7:0]       acc_q, acc_d, acc_nxt;
  logic             bank_q, bank_d;
  logic             oval_q, oval_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             out_free, load, is_last, need_out;
  logic [7:0]       type_byte;

  assign out_free = !oval_q || out_ready_i;
  assign is_last  = ((idx_q + LEN_W'(1)) == q_head_i.len);
  assign acc_nxt  = acc_q | ({6'b0, base_code(ram_rdata_i)} << {~idx_q[1:0], 1'b0});
  assign need_out = !q_head_i.only_bases || (idx_q[1:0] == 2'd3) || is_last;

  assign ram_raddr_o = bank_q ? (ADDR_W'(idx_q) + ADDR_W'(CHUNK_MAX)) : ADDR_W'(idx_q);

  always_comb begin
    if (q_head_i.only_bases) begin
      type_byte = (q_head_i.terminated ? CHAR_ONE : CHAR_FIVE) + {6'b0, q_head_i.len[1:0]};
    end else begin
      type_byte = q_head_i.terminated ? CHAR_ZERO : CHAR_NINE;
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    bank_d   = bank_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    load     = 1'b0;
    q_pop_o  = 1'b0;
    ram_re_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) state_d = S_TYPE;
      end
      S_TYPE: begin
        if (out_free) begin
          load    = 1'b1;
          obyte_d = type_byte;
          olast_d = 1'b0;
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        if (out_free) begin
          load    = 1'b1;
          obyte_d = {2'b0, q_head_i.len};
          olast_d = (q_head_i.len == '0);
          idx_d   = '0;
          acc_d   = '0;
          if (q_head_i.len == '0) begin
            q_pop_o = 1'b1;
            bank_d  = !bank_q;
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        ram_re_o = 1'b1;
        state_d  = S_USE;
      end
      S_USE: begin
        if (!need_out) begin
          // packed base mid-byte: gather and fetch the next one
          acc_d   = acc_nxt;
          idx_d   = idx_q + LEN_W'(1);
          state_d = S_RD;
        end else if (out_free) begin
          load    = 1'b1;
          obyte_d = q_head_i.only_bases ? acc_nxt : ram_rdata_i;
          olast_d = is_last;
          acc_d   = '0;
          idx_d   = idx_q + LEN_W'(1);
          if (is_last) begin
            q_pop_o = 1'b1;
            bank_d  = !bank_q;
            state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    oval_d = oval_q;
    if (load) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      bank_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    acc_q   <= acc_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = oval_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;

endmodule

[hw/rtl/dna_line_packer_top.sv]
// Top level of the DNA line packer: intake, record queue, output sequencer.
// Intake takes one beat per cycle; it stalls only while both line banks hold
// records not yet sent. With the output side idle, the queue, pick-up state and
// output register lie between the closing beat of a line and its type beat.
// A record: pick-up, type, length, RAM read and use per raw byte or packed base.
// Reset clears fill count, bank pointers, queue and output valid; no RAM pass.
module dna_line_packer_top #(
  parameter int unsigned CHUNK_MAX = 62
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // intake stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tuser_i,   // [0] command (0 text byte, 1 end of text)
  // record stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o    // last beat of one line's record
);
  import dlp_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2*CHUNK_MAX);

  // queue handshake between the two sides
  logic      q_push, q_full, q_pop, q_empty;
  rec_desc_t q_desc, q_head;

  // line RAM: two banks of CHUNK_MAX bytes, one filled while the other drains
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  dlp_front #(.CHUNK_MAX(CHUNK_MAX)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_cmd_i    (s_axis_tuser_i),
    .in_byte_i   (s_axis_tdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_desc),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  dlp_ram #(.WIDTH(BYTE_W), .DEPTH(2*CHUNK_MAX)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // hold closed lines until the output side has sent them
  dlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (q_desc),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  dlp_back #(.CHUNK_MAX(CHUNK_MAX)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

  // no record is pushed over a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("record pushed into full queue");

  // a record is retired only if one is present
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty) else $error("record popped from empty queue");

  // retiring a record puts its last beat on the output next cycle
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("record retired without a last beat");

endmodule
